>>> hw/rtl/usb_host_control_transfer_fsm_assert.svh
// assertion macros used by the port-level checker file
`ifndef USB_HOST_CONTROL_TRANSFER_FSM_ASSERT_SVH
`define USB_HOST_CONTROL_TRANSFER_FSM_ASSERT_SVH

// clocked assertion, quiet while reset is high
`define USBCTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define USBCTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/usbctl_pkg.sv
// shared codes and defaults for the usb control transfer sequencer
package usbctl_pkg;

  localparam int unsigned MAX_PACKET_DEF = 64;
  localparam int unsigned MAX_STAGES_DEF = 255;

  localparam int unsigned STAGE_W  = 3;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ANSWER_W = 3;
  localparam int unsigned PID_W    = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned NSTAGE_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef logic [STAGE_W-1:0]  stage_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [ANSWER_W-1:0] answer_t;
  typedef logic [PID_W-1:0]    pid_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [OFFSET_W-1:0] offset_t;

  localparam stage_t ST_SETUP_BEGIN  = 3'd0;
  localparam stage_t ST_SETUP_END    = 3'd1;
  localparam stage_t ST_DATA_BEGIN   = 3'd2;
  localparam stage_t ST_DATA_END     = 3'd3;
  localparam stage_t ST_STATUS_BEGIN = 3'd4;
  localparam stage_t ST_STATUS_END   = 3'd5;
  localparam stage_t ST_COMPLETE     = 3'd6;
  localparam stage_t ST_ERROR        = 3'd7;

  localparam answer_t ANS_NONE  = 3'd0;
  localparam answer_t ANS_ACK   = 3'd1;
  localparam answer_t ANS_DATA0 = 3'd2;
  localparam answer_t ANS_DATA1 = 3'd3;
  localparam answer_t ANS_STALL = 3'd4;
  localparam answer_t ANS_OTHER = 3'd5;

  localparam action_t ACT_NONE     = 3'd0;
  localparam action_t ACT_SETUP    = 3'd1;
  localparam action_t ACT_IN       = 3'd2;
  localparam action_t ACT_PUSH_OUT = 3'd3;
  localparam action_t ACT_OUT      = 3'd4;
  localparam action_t ACT_POP      = 3'd5;

  localparam pid_t PID_SETUP = 2'd0;
  localparam pid_t PID_IN    = 2'd1;
  localparam pid_t PID_OUT0  = 2'd2;
  localparam pid_t PID_OUT1  = 2'd3;

  localparam count_t SETUP_BYTES = 7'd8;

  // register indexes; device address (index 0) only feeds the token generator
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_STAGES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TRANSFER = 2'd3;

endpackage

>>> hw/rtl/usb_host_control_transfer_fsm.sv
// usb host control transfer sequencer, top level
// Takes one step beat per clock when the result register is free or being
// drained in the same cycle; each result shows the cycle after its step beat
// is taken, so the sustained rate while the receiver drains is one step per
// cycle. The single stage register and its counters are updated once per
// beat, which sets that rate. The device address register is not stored
// here: it belongs to the token generator and shows in no result field.
module usb_host_control_transfer_fsm #(
  parameter int unsigned MAX_PACKET = usbctl_pkg::MAX_PACKET_DEF,
  parameter int unsigned MAX_STAGES = usbctl_pkg::MAX_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [usbctl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [usbctl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic                                  attached,
  input  usbctl_pkg::answer_t                   answer,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output usbctl_pkg::stage_t                    stage,
  output usbctl_pkg::action_t                   action,
  output usbctl_pkg::pid_t                      token_pid,
  output usbctl_pkg::count_t                    byte_count,
  output usbctl_pkg::offset_t                   data_offset,
  output logic                                  wait_for_connection
);
  import usbctl_pkg::*;

  // configuration
  count_t               stage_bytes;
  logic [NSTAGE_W-1:0]  data_stages;
  logic                 read_transfer;

  // sequencer state
  stage_t               current_stage, current_stage_next;
  logic [NSTAGE_W-1:0]  stages_left, stages_left_next;
  offset_t              buffer_offset, buffer_offset_next;
  logic                 out_toggle, out_toggle_next;

  action_t              action_next;
  pid_t                 pid_next;
  count_t               count_next;
  offset_t              offset_next;
  logic                 wait_next;

  count_t               chunk;
  logic [NSTAGE_W-1:0]  stage_cnt;
  logic                 accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign chunk     = (32'(stage_bytes) > MAX_PACKET) ? COUNT_W'(MAX_PACKET) : stage_bytes;
  assign stage_cnt = (32'(data_stages) > MAX_STAGES) ? NSTAGE_W'(MAX_STAGES) : data_stages;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_bytes   <= '0;
      data_stages   <= '0;
      read_transfer <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STAGE_BYTES:   stage_bytes   <= cfg_data[COUNT_W-1:0];
        REG_DATA_STAGES:   data_stages   <= cfg_data[NSTAGE_W-1:0];
        REG_READ_TRANSFER: read_transfer <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    current_stage_next = current_stage;
    stages_left_next   = stages_left;
    buffer_offset_next = buffer_offset;
    out_toggle_next    = out_toggle;
    action_next        = ACT_NONE;
    pid_next           = PID_SETUP;
    count_next         = '0;
    offset_next        = '0;
    wait_next          = 1'b0;

    if (cmd) begin
      current_stage_next = ST_SETUP_BEGIN;
    end else if (!attached) begin
      current_stage_next = ST_ERROR;
      wait_next          = 1'b1;
    end else begin
      case (current_stage)
        ST_SETUP_BEGIN: begin
          stages_left_next   = stage_cnt;
          buffer_offset_next = '0;
          action_next        = ACT_SETUP;
          count_next         = SETUP_BYTES;
          current_stage_next = ST_SETUP_END;
        end
        ST_SETUP_END: begin
          if (answer == ANS_ACK) begin
            current_stage_next = (stages_left == '0) ? ST_STATUS_BEGIN : ST_DATA_BEGIN;
          end else if (answer != ANS_NONE) begin
            current_stage_next = ST_SETUP_BEGIN;
          end
        end
        ST_DATA_BEGIN: begin
          if (read_transfer) begin
            action_next = ACT_IN;
            pid_next    = PID_IN;
          end else begin
            action_next = ACT_PUSH_OUT;
            pid_next    = out_toggle ? PID_OUT1 : PID_OUT0;
            count_next  = chunk;
            offset_next = buffer_offset;
          end
          current_stage_next = ST_DATA_END;
        end
        ST_DATA_END: begin
          // a good beat is ack on a write, data0/1 on a read
          if ((answer == ANS_ACK && !read_transfer) ||
              ((answer == ANS_DATA0 || answer == ANS_DATA1) && read_transfer)) begin
            if (read_transfer) begin
              action_next = ACT_POP;
              count_next  = chunk;
              offset_next = buffer_offset;
            end else begin
              out_toggle_next = !out_toggle;
            end
            buffer_offset_next = buffer_offset + OFFSET_W'(chunk);
            if (stages_left > NSTAGE_W'(1)) begin
              stages_left_next   = stages_left - NSTAGE_W'(1);
              current_stage_next = ST_DATA_BEGIN;
            end else begin
              current_stage_next = ST_STATUS_BEGIN;
            end
          end else if (answer == ANS_DATA0 || answer == ANS_DATA1 ||
                       answer == ANS_STALL) begin
            current_stage_next = ST_SETUP_BEGIN;
          end else if (answer != ANS_NONE && answer != ANS_ACK) begin
            current_stage_next = ST_DATA_BEGIN;
          end
        end
        ST_STATUS_BEGIN: begin
          if (read_transfer) begin
            action_next = ACT_OUT;
            pid_next    = out_toggle ? PID_OUT1 : PID_OUT0;
          end else begin
            action_next = ACT_IN;
            pid_next    = PID_IN;
          end
          current_stage_next = ST_STATUS_END;
        end
        ST_STATUS_END: begin
          if (answer == ANS_ACK) begin
            if (read_transfer) current_stage_next = ST_COMPLETE;
          end else if (answer == ANS_DATA0 || answer == ANS_DATA1) begin
            if (!read_transfer) current_stage_next = ST_COMPLETE;
          end else if (answer == ANS_STALL) begin
            current_stage_next = ST_SETUP_BEGIN;
          end else if (answer != ANS_NONE) begin
            current_stage_next = ST_STATUS_BEGIN;
          end
        end
        default: ;  // complete and error wait for a start
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_stage <= ST_COMPLETE;
      stages_left   <= '0;
      buffer_offset <= '0;
      out_toggle    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        current_stage <= current_stage_next;
        stages_left   <= stages_left_next;
        buffer_offset <= buffer_offset_next;
        out_toggle    <= out_toggle_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      stage               <= current_stage_next;
      action              <= action_next;
      token_pid           <= pid_next;
      byte_count          <= count_next;
      data_offset         <= offset_next;
      wait_for_connection <= wait_next;
    end
  end

endmodule

>>> hw/rtl/usbctl_checker.sv
// port-level checks for the usb control transfer sequencer, with bind
`include "usb_host_control_transfer_fsm_assert.svh"

module usbctl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              cmd,
  input logic                              out_valid,
  input logic                              out_ready,
  input usbctl_pkg::stage_t                stage,
  input usbctl_pkg::action_t               action,
  input usbctl_pkg::pid_t                  token_pid,
  input usbctl_pkg::count_t                byte_count,
  input logic                              wait_for_connection
);
  import usbctl_pkg::*;

  // reset empties the result register
  `USBCTL_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // a held result keeps its payload
  `USBCTL_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(stage) && $stable(action), "result changed while stalled")

  // a start beat lands on setup with no action
  `USBCTL_ASSERT(a_start, in_valid && in_ready && cmd |=> out_valid && stage == ST_SETUP_BEGIN && action == ACT_NONE, "start did not reach setup")

  // detachment only ever reports the error stage, quietly
  `USBCTL_ASSERT(a_detach, out_valid && wait_for_connection |-> stage == ST_ERROR && action == ACT_NONE, "bad detach result")

  // setup always carries the 8 request bytes on a setup pid
  `USBCTL_ASSERT(a_setup, out_valid && action == ACT_SETUP |-> byte_count == SETUP_BYTES && token_pid == PID_SETUP && stage == ST_SETUP_END, "bad setup result")

endmodule

bind usb_host_control_transfer_fsm usbctl_checker u_usbctl_checker (.*);

>>> verif/testbench.sv
// self-checking testbench for the usb host control transfer sequencer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import usbctl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  typedef struct packed {
    stage_t  stage;
    action_t action;
    pid_t    pid;
    count_t  count;
    offset_t offset;
    logic    waitc;
  } stage_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic attached = 1'b1;
  answer_t answer = ANS_NONE;
  logic out_valid;
  logic out_ready = 1'b0;
  stage_t stage;
  action_t action;
  pid_t token_pid;
  count_t byte_count;
  offset_t data_offset;
  logic wait_for_connection;

  usb_host_control_transfer_fsm i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .attached(attached), .answer(answer),
    .out_valid(out_valid), .out_ready(out_ready),
    .stage(stage), .action(action), .token_pid(token_pid),
    .byte_count(byte_count), .data_offset(data_offset),
    .wait_for_connection(wait_for_connection)
  );

  always #10 clk = ~clk;

  // predicted sequencer state and its settings
  logic [6:0] cfg_stage_bytes = '0;
  logic [7:0] cfg_data_stages = '0;
  logic cfg_read = 1'b0;
  stage_t cur_stage = ST_COMPLETE;
  logic [7:0] stages_left = '0;
  offset_t buf_offset = '0;
  logic out_toggle = 1'b0;

  stage_report_t pending_reports[$];
  int error_count = 0;

  sink_mode_t sink_mode = SINK_RANDOM;
  bit source_gaps = 1'b1;
  int burst_left = 0;
  int holdoffs_asked = 0;
  int holdoffs_done = 0;
  int hold_left = 0;
  int pattern_pos = 0;
  int idle_cycles = 0;

  function automatic count_t chunk_bytes();
    return (cfg_stage_bytes > MAX_PACKET_DEF) ? count_t'(MAX_PACKET_DEF) : cfg_stage_bytes;
  endfunction

  function automatic void finish_data_stage();
    buf_offset = buf_offset + offset_t'(chunk_bytes());
    if (stages_left > 8'd1) begin
      stages_left = stages_left - 8'd1;
      cur_stage = ST_DATA_BEGIN;
    end else begin
      cur_stage = ST_STATUS_BEGIN;
    end
  endfunction

  function automatic stage_report_t advance_sequencer(logic start, logic present, answer_t ans);
    stage_report_t r;
    r = '0;
    if (start) begin
      cur_stage = ST_SETUP_BEGIN;
    end else if (!present) begin
      cur_stage = ST_ERROR;
      r.waitc = 1'b1;
    end else begin
      case (cur_stage)
        ST_SETUP_BEGIN: begin
          stages_left = (cfg_data_stages > MAX_STAGES_DEF) ? 8'(MAX_STAGES_DEF) : cfg_data_stages;
          buf_offset = '0;
          r.action = ACT_SETUP;
          r.pid = PID_SETUP;
          r.count = SETUP_BYTES;
          cur_stage = ST_SETUP_END;
        end
        ST_SETUP_END: begin
          if (ans == ANS_ACK)
            cur_stage = (stages_left == 8'd0) ? ST_STATUS_BEGIN : ST_DATA_BEGIN;
          else if (ans != ANS_NONE)
            cur_stage = ST_SETUP_BEGIN;
        end
        ST_DATA_BEGIN: begin
          if (cfg_read) begin
            r.action = ACT_IN;
            r.pid = PID_IN;
          end else begin
            r.action = ACT_PUSH_OUT;
            r.pid = out_toggle ? PID_OUT1 : PID_OUT0;
            r.count = chunk_bytes();
            r.offset = buf_offset;
          end
          cur_stage = ST_DATA_END;
        end
        ST_DATA_END: begin
          case (ans)
            ANS_NONE: ;
            ANS_ACK: begin
              if (!cfg_read) begin
                out_toggle = ~out_toggle;
                finish_data_stage();
              end
            end
            ANS_DATA0, ANS_DATA1: begin
              if (cfg_read) begin
                r.action = ACT_POP;
                r.count = chunk_bytes();
                r.offset = buf_offset;
                finish_data_stage();
              end else begin
                cur_stage = ST_SETUP_BEGIN;
              end
            end
            ANS_STALL: cur_stage = ST_SETUP_BEGIN;
            default: cur_stage = ST_DATA_BEGIN;
          endcase
        end
        ST_STATUS_BEGIN: begin
          if (cfg_read) begin
            r.action = ACT_OUT;
            r.pid = out_toggle ? PID_OUT1 : PID_OUT0;
          end else begin
            r.action = ACT_IN;
            r.pid = PID_IN;
          end
          cur_stage = ST_STATUS_END;
        end
        ST_STATUS_END: begin
          case (ans)
            ANS_NONE: ;
            ANS_ACK: if (cfg_read) cur_stage = ST_COMPLETE;
            ANS_DATA0, ANS_DATA1: if (!cfg_read) cur_stage = ST_COMPLETE;
            ANS_STALL: cur_stage = ST_SETUP_BEGIN;
            default: cur_stage = ST_STATUS_BEGIN;
          endcase
        end
        default: ;
      endcase
    end
    r.stage = cur_stage;
    return r;
  endfunction

  // the answer that moves the current stage forward
  function automatic answer_t fitting_answer();
    case (cur_stage)
      ST_SETUP_END: return ANS_ACK;
      ST_DATA_END: return cfg_read ? ($urandom_range(0, 1) ? ANS_DATA1 : ANS_DATA0) : ANS_ACK;
      ST_STATUS_END: return cfg_read ? ANS_ACK : ($urandom_range(0, 1) ? ANS_DATA1 : ANS_DATA0);
      default: return answer_t'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_step(input logic start, input logic present, input answer_t ans);
    int gap;
    if (source_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= start;
    attached <= present;
    answer <= ans;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(advance_sequencer(start, present, ans));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // call only with the sequencer idle
  task automatic write_settings(input logic [6:0] addr, input logic [6:0] bytes,
                                input logic [7:0] stages, input logic rd);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DEVICE_ADDRESS;
    cfg_data <= {1'b0, addr};
    @(negedge clk);
    cfg_index <= REG_STAGE_BYTES;
    cfg_data <= {1'b0, bytes};
    @(negedge clk);
    cfg_index <= REG_DATA_STAGES;
    cfg_data <= stages;
    @(negedge clk);
    cfg_index <= REG_READ_TRANSFER;
    cfg_data <= {7'b0, rd};
    @(negedge clk) cfg_wr_en <= 1'b0;
    cfg_stage_bytes = bytes;
    cfg_data_stages = stages;
    cfg_read = rd;
  endtask

  task automatic run_transfers(input int steps, input int upset_pct);
    int done;
    bit idle;
    logic start;
    logic present;
    answer_t ans;
    done = 0;
    while (done < steps) begin
      idle = (cur_stage == ST_COMPLETE || cur_stage == ST_ERROR);
      if ($urandom_range(0, 99) < upset_pct) begin
        start = ($urandom_range(0, 7) == 0);
        present = ($urandom_range(0, 3) != 0);
        ans = answer_t'($urandom_range(0, 7));
      end else if (idle) begin
        start = ($urandom_range(0, 9) != 0);
        present = 1'b1;
        ans = answer_t'($urandom_range(0, 7));
      end else begin
        start = 1'b0;
        present = 1'b1;
        ans = ($urandom_range(0, 99) < 80) ? fitting_answer() : answer_t'($urandom_range(0, 7));
      end
      send_step(start, present, ans);
      if (start || !idle) done++;
    end
  endtask

  task automatic test_write_sequence();
    sink_mode = SINK_RANDOM;
    send_step(1'b0, 1'b1, ANS_NONE);   // idle after reset stays complete
    wait_idle();
    write_settings(7'd127, 7'd64, 8'd2, 1'b0);
    send_step(1'b1, 1'b0, answer_t'(3'd7));  // start ignores attached and answer
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, answer_t'(3'd6));  // undefined code retries setup
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_ACK);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_OTHER);        // retried stage keeps its offset
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_ACK);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_ACK);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_ACK);          // write status ignores ack, waits on data
    send_step(1'b0, 1'b1, ANS_DATA1);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b1, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_ACK);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_DATA0);        // data answer on a write restarts
    send_step(1'b0, 1'b0, ANS_NONE);         // detach
    send_step(1'b0, 1'b1, ANS_ACK);
    wait_idle();
  endtask

  task automatic test_read_sequence();
    write_settings(7'd0, 7'd0, 8'd1, 1'b1);
    send_step(1'b1, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_STALL);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_ACK);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_ACK);          // read data ignores ack, waits on data
    send_step(1'b0, 1'b1, ANS_DATA0);
    send_step(1'b0, 1'b1, ANS_NONE);
    send_step(1'b0, 1'b1, ANS_DATA1);        // read status ignores data, waits on ack
    send_step(1'b0, 1'b1, ANS_ACK);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_settings(7'd42, 7'd16, 8'd3, 1'b0);
    sink_mode = SINK_OPEN;
    source_gaps = 1'b0;
    holdoffs_asked++;
    run_transfers(40, 5);
    wait_idle();
    source_gaps = 1'b1;
  endtask

  task automatic test_long_transfer();
    write_settings(7'd85, 7'd127, 8'd255, 1'b0);
    sink_mode = SINK_PERIODIC;
    send_step(1'b1, 1'b1, ANS_NONE);
    // only waits and retries besides the fitting answer, so it runs to the end
    while (cur_stage != ST_COMPLETE)
      send_step(1'b0, 1'b1, ($urandom_range(0, 99) < 88) ? fitting_answer() :
                ($urandom_range(0, 1) ? ANS_NONE : answer_t'($urandom_range(5, 7))));
    wait_idle();
  endtask

  task automatic test_random_settings();
    logic [6:0] bytes;
    logic [7:0] stages;
    for (int p = 0; p < 7; p++) begin
      case ($urandom_range(0, 3))
        0: bytes = 7'd0;
        1: bytes = 7'd64;
        2: bytes = 7'd127;
        default: bytes = 7'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 3))
        0: stages = 8'd0;
        1: stages = 8'd1;
        default: stages = 8'($urandom_range(2, 6));
      endcase
      write_settings(7'($urandom_range(0, 127)), bytes, stages, 1'($urandom_range(0, 1)));
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      source_gaps = (p != 2);
      if (p == 2) sink_mode = SINK_OPEN;
      run_transfers(110, 5 + 3 * p);
      wait_idle();
    end
  endtask

  // receiver: stall pattern of its own, plus long hold-offs on request
  always @(negedge clk) begin
    if (holdoffs_done != holdoffs_asked) begin
      hold_left = HOLD_OFF_CYCLES;
      holdoffs_done = holdoffs_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      pattern_pos++;
      case (sink_mode)
        SINK_OPEN: out_ready <= 1'b1;
        SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((pattern_pos % 9) < 5);
      endcase
    end
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    stage_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual stage %0d action %0d",
                 $time, stage, action);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("stage", want.stage, stage);
        check_field("action", want.action, action);
        check_field("token_pid", want.pid, token_pid);
        check_field("byte_count", want.count, byte_count);
        check_field("data_offset", want.offset, data_offset);
        check_field("wait_for_connection", want.waitc, wait_for_connection);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_write_sequence();
    test_read_sequence();
    test_backpressure();
    test_long_transfer();
    test_random_settings();
    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
